// File: src/header_length_frame_extractor_top_defines.svh
// ----------------------------------------------------------------------------
// header_length_frame_extractor_top_defines.svh
// assertion macros used by the frame extractor parser
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_FRAME_EXTRACTOR_TOP_DEFINES_SVH
`define HEADER_LENGTH_FRAME_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// check that holds whenever reset is released
`define HLFE_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hlfe assertion failed");

// check that holds at every edge, reset included
`define HLFE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hlfe assertion failed");

`else

`define HLFE_ASSERT_RST(lbl, clk, rst_n, prop)
`define HLFE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: src/hlfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfe_pkg
// types, constants and register codes of the header/length frame extractor
// ----------------------------------------------------------------------------
package hlfe_pkg;

    // largest candidate frame, counted from the first header byte
    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    // width that holds both the byte count and length plus three
    localparam int LEN_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_CMD_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_CMD_B  = 2'd3;

    // register reset values
    localparam logic [7:0] RST_HEADER_FIRST  = 8'h5A;
    localparam logic [7:0] RST_HEADER_SECOND = 8'hA5;
    localparam logic [7:0] RST_ACCEPT_CMD_A  = 8'h81;
    localparam logic [7:0] RST_ACCEPT_CMD_B  = 8'h83;

    typedef enum logic {
        PH_HUNT,
        PH_COLLECT
    } t_phase;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] accept_cmd_a;
        logic [7:0] accept_cmd_b;
    } t_cfg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] body_index;
        logic       last;
    } t_result;

endpackage

// File: src/hlfe_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfe_rx_if
// received byte channel, one byte per request
// ----------------------------------------------------------------------------
interface hlfe_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/hlfe_frame_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfe_frame_if
// delivered frame byte channel with index and last mark
// ----------------------------------------------------------------------------
interface hlfe_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [7:0] body_index;
    logic       last;

    modport source (output valid, output frame_byte, output body_index, output last,
                    input ready);
    modport sink (input valid, input frame_byte, input body_index, input last,
                  output ready);
endinterface

// File: src/hlfe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfe_cfg_regs
// configuration registers: header bytes and accepted command codes
// ----------------------------------------------------------------------------
module hlfe_cfg_regs
    import hlfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // write decoder
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                CFG_HEADER_FIRST:  n_cfg.header_first  = i_data;
                CFG_HEADER_SECOND: n_cfg.header_second = i_data;
                CFG_ACCEPT_CMD_A:  n_cfg.accept_cmd_a  = i_data;
                CFG_ACCEPT_CMD_B:  n_cfg.accept_cmd_b  = i_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= RST_HEADER_FIRST;
            r_cfg.header_second <= RST_HEADER_SECOND;
            r_cfg.accept_cmd_a  <= RST_ACCEPT_CMD_A;
            r_cfg.accept_cmd_b  <= RST_ACCEPT_CMD_B;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/hlfe_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfe_parser
// frame hunting state machine: header check, length capture, body delivery
// ----------------------------------------------------------------------------
`include "header_length_frame_extractor_top_defines.svh"

module hlfe_parser
    import hlfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_FOUR  = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME_BYTES);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_len, n_len;
    logic             r_bad, n_bad;
    logic             r_deliver, n_deliver;

    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] idx_full;
    logic [LEN_W-1:0] len_p3;
    logic             len_ok;
    logic             cmd_ok;
    logic             res_last;

    // per-byte helpers
    assign cnt_inc  = r_count + CNT_ONE;
    assign idx_full = cnt_inc - CNT_FOUR;
    assign len_p3   = LEN_W'(r_len) + LEN_W'(3);
    assign len_ok   = (r_len >= 8'd2) && (len_p3 <= LEN_MAX);
    assign cmd_ok   = (i_byte == i_cfg.accept_cmd_a) || (i_byte == i_cfg.accept_cmd_b);

    // next state and result
    always_comb begin
        n_phase          = r_phase;
        n_count          = r_count;
        n_len            = r_len;
        n_bad            = r_bad;
        n_deliver        = r_deliver;
        o_res_valid      = 1'b0;
        o_res.frame_byte = i_byte;
        o_res.body_index = 8'(idx_full);
        o_res.last       = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == i_cfg.header_first) begin
                        n_phase   = PH_COLLECT;
                        n_count   = CNT_ONE;
                        n_bad     = 1'b0;
                        n_deliver = 1'b0;
                    end
                end
                PH_COLLECT: begin
                    n_count = cnt_inc;
                    if (cnt_inc == CNT_TWO) begin
                        n_bad = (i_byte != i_cfg.header_second);
                    end else if (cnt_inc == CNT_THREE) begin
                        n_len = i_byte;
                    end else if (cnt_inc == CNT_FOUR) begin
                        // command byte: drop the candidate or decide delivery
                        if (r_bad) begin
                            n_phase = PH_HUNT;
                            n_count = '0;
                        end else begin
                            n_deliver        = len_ok && cmd_ok;
                            o_res_valid      = len_ok && cmd_ok;
                            o_res.body_index = 8'd0;
                        end
                    end else if (LEN_W'(cnt_inc) == len_p3) begin
                        // final body byte
                        n_phase          = PH_HUNT;
                        n_count          = '0;
                        n_deliver        = 1'b0;
                        o_res_valid      = r_deliver;
                        o_res.body_index = r_len - 8'd1;
                        o_res.last       = 1'b1;
                    end else if (cnt_inc >= CNT_MAX) begin
                        // bad length runs out the full frame span
                        n_phase   = PH_HUNT;
                        n_count   = '0;
                        n_deliver = 1'b0;
                    end else begin
                        o_res_valid = r_deliver;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_count = '0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_len     <= '0;
            r_bad     <= 1'b0;
            r_deliver <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_len     <= n_len;
            r_bad     <= n_bad;
            r_deliver <= n_deliver;
        end
    end

    // final byte of a delivered frame
    assign res_last = o_res_valid && o_res.last;

    // checks
    `HLFE_ASSERT_RST(a_res_in_collect, i_clk, i_rst_n, o_res_valid |-> (r_phase == PH_COLLECT))
    `HLFE_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_MAX)
    `HLFE_ASSERT_RST(a_hunt_count_zero, i_clk, i_rst_n, (r_phase == PH_HUNT) |-> (r_count == '0))
    `HLFE_ASSERT_RST(a_last_ends_frame, i_clk, i_rst_n, res_last |=> (r_phase == PH_HUNT))

endmodule

// File: src/hlfe_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfe_out_stage
// result register between the parser and the frame channel
// ----------------------------------------------------------------------------
module hlfe_out_stage
    import hlfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_take
);

    logic    r_valid, n_valid;
    t_result r_res;

    // room for a new result when empty or draining this cycle
    assign o_take = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload holds until replaced
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: src/header_length_frame_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_length_frame_extractor_top
// finds header/length framed packets in a byte stream, delivers accepted ones
// ----------------------------------------------------------------------------
//  channel   dir  payload                           request
//  i_rx      in   rx_byte[7:0]                      valid & ready
//  o_frame   out  frame_byte[7:0] body_index[7:0]   valid & ready
//                 last
//  i_cfg_*   in   idx[1:0] data[7:0]                i_cfg_we
//
//  one byte per cycle unless a held result is stalled by the sink; each byte is
//  parsed in the cycle it is taken and its result lands in the output register
//  at the next clock edge; a held result only blocks input when the sink stalls it;
//  while it drains the next byte is still taken
//  synchronous active low reset; no clearing pass
// ----------------------------------------------------------------------------
module header_length_frame_extractor_top
    import hlfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hlfe_rx_if.sink               i_rx,
    hlfe_frame_if.source          o_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result res;
    t_result out_res;
    logic    res_valid;
    logic    take;
    logic    accept;

    assign i_rx.ready = take;
    assign accept     = i_rx.valid && take;

    // configuration
    hlfe_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // frame parser
    hlfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    hlfe_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && res_valid),
        .i_res   (res),
        .i_ready (o_frame.ready),
        .o_valid (o_frame.valid),
        .o_res   (out_res),
        .o_take  (take)
    );

    assign o_frame.frame_byte = out_res.frame_byte;
    assign o_frame.body_index = out_res.body_index;
    assign o_frame.last       = out_res.last;

endmodule

// File: tb/hlfe_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlfe_frame_checker
// watches the byte and frame channels and the register port, predicts the
// delivered frame bytes from every accepted byte and compares each delivered
// byte, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module hlfe_frame_checker
    import hlfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    input  logic                  i_rx_ready,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_valid,
    input  logic                  i_frame_ready,
    input  logic [7:0]            i_frame_byte,
    input  logic [7:0]            i_body_index,
    input  logic                  i_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    // predicted deframer state and register copy
    t_cfg       cfg;
    t_phase     phase;
    int         byte_count;
    logic [7:0] frame_len;
    logic       hdr2_bad;
    logic       deliver;

    t_result    bytes_due [$];
    int         fail_n;

    task automatic queue_byte(input logic [7:0] b, input int idx, input logic fin);
        t_result r;
        r.frame_byte = b;
        r.body_index = 8'(idx);
        r.last       = fin;
        bytes_due.push_back(r);
    endtask

    // advance the deframer by one received byte
    task automatic parse_byte(input logic [7:0] b);
        int len;
        if (phase != PH_COLLECT) begin
            if (b == cfg.header_first) begin
                phase      = PH_COLLECT;
                byte_count = 1;
                hdr2_bad   = 1'b0;
                deliver    = 1'b0;
            end
        end else begin
            byte_count++;
            len = frame_len;
            if (byte_count == 2) begin
                hdr2_bad = (b != cfg.header_second);
            end else if (byte_count == 3) begin
                frame_len = b;
            end else if (byte_count == 4) begin
                // command byte: bad second header drops the candidate here
                if (hdr2_bad) begin
                    phase      = PH_HUNT;
                    byte_count = 0;
                end else begin
                    deliver = (len >= 2) && (len + 3 <= MAX_FRAME_BYTES) &&
                              (b == cfg.accept_cmd_a || b == cfg.accept_cmd_b);
                    if (deliver) queue_byte(b, 0, 1'b0);
                end
            end else if (byte_count == len + 3) begin
                if (deliver) queue_byte(b, len - 1, 1'b1);
                phase      = PH_HUNT;
                byte_count = 0;
                deliver    = 1'b0;
            end else if (byte_count >= MAX_FRAME_BYTES) begin
                // bad length runs out the largest frame
                phase      = PH_HUNT;
                byte_count = 0;
                deliver    = 1'b0;
            end else if (deliver) begin
                queue_byte(b, byte_count - 4, 1'b0);
            end
        end
    endtask

    // compare one delivered byte against the oldest prediction
    task automatic check_byte();
        t_result want;
        if (bytes_due.size() == 0) begin
            fail_n++;
            if (fail_n <= 10)
                $display("unexpected frame byte %02h idx %0d last %0b, none due",
                         i_frame_byte, i_body_index, i_last);
        end else begin
            want = bytes_due.pop_front();
            if (i_frame_byte !== want.frame_byte || i_body_index !== want.body_index ||
                i_last !== want.last) begin
                fail_n++;
                if (fail_n <= 10)
                    $display("frame byte want %02h idx %0d last %0b, got %02h idx %0d last %0b",
                             want.frame_byte, want.body_index, want.last,
                             i_frame_byte, i_body_index, i_last);
            end
        end
    endtask

    // sample requests on each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.header_first  = RST_HEADER_FIRST;
            cfg.header_second = RST_HEADER_SECOND;
            cfg.accept_cmd_a  = RST_ACCEPT_CMD_A;
            cfg.accept_cmd_b  = RST_ACCEPT_CMD_B;
            phase             = PH_HUNT;
            byte_count        = 0;
            frame_len         = '0;
            hdr2_bad          = 1'b0;
            deliver           = 1'b0;
            bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEADER_FIRST:  cfg.header_first  = i_cfg_data;
                    CFG_HEADER_SECOND: cfg.header_second = i_cfg_data;
                    CFG_ACCEPT_CMD_A:  cfg.accept_cmd_a  = i_cfg_data;
                    CFG_ACCEPT_CMD_B:  cfg.accept_cmd_b  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx_valid && i_rx_ready) parse_byte(i_rx_byte);
            if (i_frame_valid && i_frame_ready) check_byte();
        end
        o_mismatches <= fail_n;
        o_pending    <= bytes_due.size();
    end

endmodule

// File: tb/header_length_frame_extractor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_length_frame_extractor_top_tb
// drives byte streams of good, bad and truncated frames through the frame
// extractor under several header and command settings, with random gaps on
// both channels; the frame checker judges every delivered byte
// ----------------------------------------------------------------------------
module header_length_frame_extractor_top_tb;
    import hlfe_pkg::*;

    localparam int         PHASES       = 6;
    localparam int         PHASE_BYTES  = 300;
    localparam int         LONG_HOLD    = 400;
    localparam logic [7:0] REJECTED_CMD = 8'h82;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    pending;

    t_cfg cur_cfg;
    int   sent;
    bit   tx_idle;
    bit   rx_idle;
    bit   long_hold;

    // opening bytes under reset settings: noise, short frames, bad second
    // header, header value inside a body, rejected command
    logic [7:0] opening [27] = '{
        8'h00, 8'hFF,
        RST_HEADER_FIRST, RST_HEADER_SECOND, 8'd2, RST_ACCEPT_CMD_A, 8'hFF,
        RST_HEADER_FIRST, RST_HEADER_SECOND, 8'd3, RST_ACCEPT_CMD_B, RST_HEADER_FIRST, 8'h00,
        RST_HEADER_FIRST, RST_HEADER_FIRST, RST_ACCEPT_CMD_A, RST_ACCEPT_CMD_A,
        RST_HEADER_FIRST, RST_HEADER_SECOND, 8'd2, REJECTED_CMD, RST_HEADER_FIRST,
        RST_HEADER_FIRST, RST_HEADER_SECOND, 8'd2, RST_ACCEPT_CMD_B, 8'h00
    };

    hlfe_rx_if    rx_if ();
    hlfe_frame_if frame_if ();

    header_length_frame_extractor_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_rx       (rx_if),
        .o_frame    (frame_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hlfe_frame_checker u_frame_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_rx_valid    (rx_if.valid),
        .i_rx_ready    (rx_if.ready),
        .i_rx_byte     (rx_if.rx_byte),
        .i_frame_valid (frame_if.valid),
        .i_frame_ready (frame_if.ready),
        .i_frame_byte  (frame_if.frame_byte),
        .i_body_index  (frame_if.body_index),
        .i_last        (frame_if.last),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // 50 MHz clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // frame sink: random stalls, occasional long hold-off
    initial begin
        int stall;
        int taken;
        taken = 0;
        forever begin
            if (long_hold) begin
                frame_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            stall = rx_idle ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                frame_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            frame_if.ready <= 1'b1;
            @(posedge clk);
            while (!(frame_if.valid && frame_if.ready) && !long_hold) @(posedge clk);
            taken++;
            if (taken % 50 == 0) rx_idle = ($urandom_range(0, 2) != 0);
        end
    end

    // one byte request, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!(rx_if.valid && rx_if.ready)) @(posedge clk);
        sent++;
    endtask

    // body bytes often carry the first header value
    function automatic logic [7:0] body_byte();
        if ($urandom_range(0, 99) < 15) return cur_cfg.header_first;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_cmd();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return cur_cfg.accept_cmd_a;
        if (r < 8) return cur_cfg.accept_cmd_b;
        return 8'($urandom);
    endfunction

    task automatic send_frame(input logic [7:0] second, input logic [7:0] len,
                              input logic [7:0] cmd, input int body_n);
        send_byte(cur_cfg.header_first);
        send_byte(second);
        send_byte(len);
        send_byte(cmd);
        repeat (body_n) send_byte(body_byte());
    endtask

    // one random stretch of the stream
    task automatic send_unit();
        int kind;
        int n;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
            // well formed frame, mostly short
            n = $urandom_range(0, 99);
            if (n < 88) len = $urandom_range(2, 12);
            else if (n < 99) len = $urandom_range(13, 64);
            else len = $urandom_range(200, MAX_FRAME_BYTES - 3);
            send_frame(cur_cfg.header_second, 8'(len), pick_cmd(), len - 1);
        end else if (kind < 74) begin
            // wrong second header
            send_frame(cur_cfg.header_second ^ 8'($urandom_range(1, 255)), 8'($urandom),
                       pick_cmd(), 0);
        end else if (kind < 75) begin
            // length out of range
            case ($urandom_range(0, 3))
                0: len = 0;
                1: len = 1;
                2: len = MAX_FRAME_BYTES - 2;
                default: len = 255;
            endcase
            send_frame(cur_cfg.header_second, 8'(len), pick_cmd(), MAX_FRAME_BYTES - 4);
        end else if (kind < 87) begin
            // header cut short, the next bytes fall into the candidate
            send_byte(cur_cfg.header_first);
            repeat ($urandom_range(0, 3)) send_byte(body_byte());
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(body_byte());
        end
    endtask

    // stop sending and wait for every predicted byte to drain
    task automatic settle();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register writes, one per cycle, only while idle
    task automatic write_cfg(input t_cfg c);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HEADER_FIRST;
        cfg_data <= c.header_first;
        @(posedge clk);
        cfg_idx  <= CFG_HEADER_SECOND;
        cfg_data <= c.header_second;
        @(posedge clk);
        cfg_idx  <= CFG_ACCEPT_CMD_A;
        cfg_data <= c.accept_cmd_a;
        @(posedge clk);
        cfg_idx  <= CFG_ACCEPT_CMD_B;
        cfg_data <= c.accept_cmd_b;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_cfg = c;
    endtask

    // stimulus
    initial begin
        int   p;
        int   stop_at;
        bit   paused;
        t_cfg c;
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        cfg_we        <= 1'b0;
        cfg_idx       <= '0;
        cfg_data      <= '0;
        cur_cfg = {RST_HEADER_FIRST, RST_HEADER_SECOND, RST_ACCEPT_CMD_A, RST_ACCEPT_CMD_B};
        sent    = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        paused  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[k]) send_byte(opening[k]);

        for (p = 0; p < PHASES; p++) begin
            settle();
            // register settings per phase, extremes first
            if (p > 0) begin
                c = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
                case (p)
                    1: c = {8'h00, 8'hFF, 8'h00, 8'hFF};
                    2: c = {8'hFF, 8'h00, 8'hFF, 8'h00};
                    3: c.accept_cmd_b = c.accept_cmd_a;
                    5: c = {RST_HEADER_FIRST, RST_HEADER_SECOND,
                            RST_ACCEPT_CMD_A, RST_ACCEPT_CMD_B};
                    default: ;
                endcase
                write_cfg(c);
            end
            stop_at = sent + PHASE_BYTES;

            // long frames and bad lengths that span the whole frame limit
            case (p)
                1: send_frame(cur_cfg.header_second, 8'd0, pick_cmd(), MAX_FRAME_BYTES - 4);
                2: begin
                    long_hold = 1'b1;
                    send_frame(cur_cfg.header_second, 8'(MAX_FRAME_BYTES - 3),
                               cur_cfg.accept_cmd_a, MAX_FRAME_BYTES - 4);
                end
                4: send_frame(cur_cfg.header_second, 8'd255, pick_cmd(), MAX_FRAME_BYTES - 4);
                default: ;
            endcase

            while (sent < stop_at) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                send_unit();
                if (p == 3 && !paused && sent > stop_at - PHASE_BYTES / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/hlfe_pkg.sv
src/hlfe_rx_if.sv
src/hlfe_frame_if.sv
src/hlfe_cfg_regs.sv
src/hlfe_parser.sv
src/hlfe_out_stage.sv
src/header_length_frame_extractor_top.sv
tb/hlfe_frame_checker.sv
tb/header_length_frame_extractor_top_tb.sv
